// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gfbr_pkg.sv -----
// Shared constants, font tables, opcodes and the controller command type.
`default_nettype none

package gfbr_pkg;

	localparam int COLUMNS     = 128;
	localparam int ROWS        = 64;
	localparam int PAGES       = (ROWS + 7) / 8;
	localparam int STORE_DEPTH = COLUMNS * PAGES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int SMALL_W     = 5;
	localparam int TEXT_STEPS  = SMALL_W + 1;
	localparam int GLYPHS      = 11;
	localparam int BLANK_GLYPH = 10;
	localparam int DIGIT_MAX   = 9;
	localparam int BIG_W       = 16;
	localparam int BIG_STEPS   = 2 * BIG_W;
	localparam int BIG_COUNT   = 6;
	localparam int DBL_W       = 10;
	localparam int DBL_STEPS   = 2 * DBL_W;

	// Rows of the last page that lie on the screen.
	localparam int LAST_ROWS = ROWS - (PAGES - 1) * 8;
	localparam logic [7:0] LAST_PAGE_MASK = 8'((1 << LAST_ROWS) - 1);

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_TEXT   = 3'd1;
	localparam logic [2:0] OP_BIG    = 3'd2;
	localparam logic [2:0] OP_DOUBLE = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	typedef struct packed {
		logic              load;
		logic              run;
		logic [2:0]        kind;
		logic [ADDR_W-1:0] step;
		logic              publish;
	} gfbr_cmd_t;

	localparam logic [7:0] SMALL_FONT [GLYPHS][SMALL_W] = '{
		'{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
		'{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
		'{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
		'{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
		'{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
		'{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
		'{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
		'{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [7:0] BIG_FONT [BIG_COUNT][BIG_STEPS] = '{
		'{8'h40, 8'h42, 8'hCC, 8'h00, 8'h08, 8'h48, 8'h48, 8'h7F,
		  8'h48, 8'h48, 8'h7F, 8'h48, 8'h48, 8'h08, 8'h00, 8'h00,
		  8'h40, 8'h20, 8'h1F, 8'h20, 8'h44, 8'h4A, 8'h49, 8'h48,
		  8'h48, 8'h48, 8'h48, 8'h49, 8'h4A, 8'h44, 8'h40, 8'h00},
		'{8'h10, 8'h10, 8'h10, 8'hFF, 8'h10, 8'h90, 8'h08, 8'h88,
		  8'h69, 8'h59, 8'h4B, 8'h4D, 8'h69, 8'h88, 8'h08, 8'h00,
		  8'h04, 8'h44, 8'h82, 8'h7F, 8'h01, 8'h80, 8'h88, 8'h88,
		  8'h88, 8'h88, 8'hFF, 8'h88, 8'h88, 8'h88, 8'h80, 8'h00},
		'{8'h08, 8'h08, 8'hFD, 8'h0A, 8'h08, 8'h00, 8'h08, 8'h08,
		  8'hFD, 8'h0A, 8'h08, 8'h00, 8'hFE, 8'h22, 8'h22, 8'h00,
		  8'h10, 8'h10, 8'h1F, 8'h08, 8'h88, 8'h68, 8'h18, 8'h0E,
		  8'h09, 8'h08, 8'h08, 8'h08, 8'hFF, 8'h08, 8'h08, 8'h00},
		'{8'h00, 8'hFE, 8'h92, 8'h92, 8'h92, 8'hFE, 8'h00, 8'h02,
		  8'h02, 8'hFA, 8'h0A, 8'h0A, 8'h0A, 8'hFE, 8'h02, 8'h00,
		  8'h80, 8'h8F, 8'h44, 8'h44, 8'h24, 8'h1F, 8'h00, 8'h80,
		  8'h83, 8'h6C, 8'h10, 8'h10, 8'h6C, 8'h83, 8'h80, 8'h00},
		'{8'h00, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'hFE,
		  8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 8'h43,
		  8'h44, 8'h48, 8'h50, 8'h60, 8'h40, 8'h00, 8'h00, 8'h00},
		'{8'h20, 8'h30, 8'hAC, 8'h63, 8'h10, 8'h00, 8'h22, 8'h22,
		  8'h22, 8'hE2, 8'h12, 8'h0A, 8'h86, 8'h62, 8'h00, 8'h00,
		  8'h22, 8'h67, 8'h22, 8'h12, 8'h12, 8'h40, 8'h44, 8'h44,
		  8'h44, 8'h7F, 8'h44, 8'h44, 8'h44, 8'h40, 8'h00, 8'h00}
	};

	// Column byte of a small glyph; columns past the glyph read as blank.
	function automatic logic [7:0] small_font(input logic [3:0] g, input logic [2:0] i);
		logic [7:0] b;
		b = '0;
		if (int'(g) < GLYPHS && int'(i) < SMALL_W) begin
			b = SMALL_FONT[g][i];
		end
		return b;
	endfunction

	// Byte of a large glyph: the upper page first, then the lower page.
	function automatic logic [7:0] big_font(input logic [2:0] g, input logic [4:0] i);
		logic [7:0] b;
		b = '0;
		if (int'(g) < BIG_COUNT) begin
			b = BIG_FONT[g][i];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/gfbr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module gfbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/gfbr_datapath.sv -----
// Address and byte generation, read-modify-write stage and frame store.
`default_nettype none

module gfbr_datapath import gfbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  gfbr_cmd_t  cmd,
	input  logic [6:0] column,
	input  logic [2:0] page,
	input  logic [7:0] symbol,
	output logic [7:0] read_data
);

	logic [ADDR_W-1:0] base_q;
	logic [6:0]        col_q;
	logic [2:0]        page_q;
	logic [7:0]        sym_q;
	logic [7:0]        rd_hold_q;
	logic [7:0]        read_data_q;

	logic              valid_s1;
	logic              read_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        data_s1;
	logic [7:0]        mask_s1;

	logic [ADDR_W-1:0] addr_c;
	logic [7:0]        data_c;
	logic [7:0]        mask_c;
	logic              hi_c;
	logic [4:0]        off_c;
	logic [4:0]        dbl_j;
	logic [3:0]        text_glyph;
	logic [7:0]        font_b;
	logic [13:0]       tall;
	logic [3:0]        acc_page;
	logic [7:0]        row_mask;

	logic [7:0]        ram_rdata;
	logic [7:0]        ram_wdata;
	logic              ram_we;

	always_comb begin
		text_glyph = ((sym_q >= CHAR_ZERO) && (sym_q <= CHAR_NINE)) ?
			4'(sym_q - CHAR_ZERO) : 4'(BLANK_GLYPH);
		hi_c     = 1'b0;
		off_c    = '0;
		data_c   = '0;
		mask_c   = 8'hFF;
		dbl_j    = '0;
		font_b   = '0;
		tall     = '0;
		acc_page = '0;
		row_mask = 8'hFF;
		case (cmd.kind)
			OP_TEXT: begin
				off_c  = 5'(cmd.step[2:0]);
				data_c = small_font(text_glyph, cmd.step[2:0]);
			end
			OP_BIG: begin
				hi_c   = cmd.step[4];
				off_c  = {1'b0, cmd.step[3:0]};
				data_c = big_font(sym_q[2:0], cmd.step[4:0]);
			end
			OP_DOUBLE: begin
				// Steps cover the ten doubled columns on the drawing page, then
				// the same columns on the page below.
				hi_c   = cmd.step[4:0] >= 5'(DBL_W);
				dbl_j  = hi_c ? cmd.step[4:0] - 5'(DBL_W) : cmd.step[4:0];
				off_c  = dbl_j;
				font_b = small_font(sym_q[3:0], dbl_j[3:1]);
				for (int r = 0; r < 7; r++) begin
					tall[2*r]   = font_b[r];
					tall[2*r+1] = font_b[r];
				end
				acc_page = {1'b0, page_q} + {3'b000, hi_c};
				if (int'(acc_page) >= PAGES) begin
					row_mask = '0;
				end else if (int'(acc_page) == PAGES - 1) begin
					row_mask = LAST_PAGE_MASK;
				end
				data_c = hi_c ? {2'b00, tall[13:8]} : tall[7:0];
				mask_c = (hi_c ? 8'h3F : 8'hFF) & row_mask;
			end
			OP_READ: begin
				mask_c = '0;
			end
			OP_CLEAR: begin
				data_c = '0;
			end
			default: begin
				mask_c = '0;
			end
		endcase
		if (cmd.kind == OP_CLEAR) begin
			addr_c = cmd.step;
		end else begin
			addr_c = base_q + (hi_c ? ADDR_W'(COLUMNS) : '0) + ADDR_W'(col_q) + ADDR_W'(off_c);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= ADDR_W'(int'(page) * COLUMNS);
			col_q  <= column;
			page_q <= page;
			sym_q  <= symbol;
		end
		addr_s1 <= addr_c;
		data_s1 <= data_c;
		mask_s1 <= mask_c;
		read_s1 <= cmd.kind == OP_READ;
		if (cmd.load) begin
			rd_hold_q <= '0;
		end else if (valid_s1 && read_s1) begin
			rd_hold_q <= ram_rdata;
		end
		if (cmd.publish) begin
			read_data_q <= rd_hold_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.run;
		end
	end

	// Bits outside the mask keep their old value from the registered read.
	assign ram_wdata = (ram_rdata & ~mask_s1) | (data_s1 & mask_s1);
	assign ram_we    = valid_s1 && (mask_s1 != 8'h00);

	gfbr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.raddr(addr_c),
		.rdata(ram_rdata)
	);

	assign read_data = read_data_q;

endmodule

`default_nettype wire

// ----- rtl/gfbr_ctrl.sv -----
// Request decoder, range guards and sequencing state machine.
`default_nettype none

module gfbr_ctrl import gfbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] op,
	input  logic [6:0] column,
	input  logic [2:0] page,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepted,
	output gfbr_cmd_t  cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

	state_t            state_q;
	logic [2:0]        kind_q;
	logic [ADDR_W-1:0] step_q;
	logic [ADDR_W-1:0] last_q;
	logic              ok_q;
	logic              report_q;
	logic              out_valid_q;
	logic              accepted_q;

	logic              guard_ok;
	logic [ADDR_W-1:0] last_c;
	logic              take_in;
	logic              out_free;

	always_comb begin
		guard_ok = 1'b0;
		last_c   = '0;
		unique case (op)
			OP_CLEAR: begin
				guard_ok = 1'b1;
				last_c   = ADDR_W'(STORE_DEPTH - 1);
			end
			OP_TEXT: begin
				guard_ok = int'(page) < PAGES && int'(column) < COLUMNS - SMALL_W;
				last_c   = ADDR_W'(TEXT_STEPS - 1);
			end
			OP_BIG: begin
				guard_ok = int'(symbol) < BIG_COUNT && int'(page) + 2 <= PAGES &&
					int'(column) <= COLUMNS - BIG_W;
				last_c   = ADDR_W'(BIG_STEPS - 1);
			end
			OP_DOUBLE: begin
				guard_ok = int'(symbol) <= DIGIT_MAX && int'(page) < PAGES &&
					int'(column) <= COLUMNS - DBL_W;
				last_c   = ADDR_W'(DBL_STEPS - 1);
			end
			OP_READ: begin
				guard_ok = int'(page) < PAGES && int'(column) < COLUMNS;
				last_c   = '0;
			end
			default: begin
				guard_ok = 1'b0;
			end
		endcase
	end

	assign take_in  = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd.load    = take_in;
		cmd.run     = state_q == ST_RUN;
		cmd.kind    = kind_q;
		cmd.step    = step_q;
		cmd.publish = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// Reset starts a clearing sweep over the whole store.
			state_q     <= ST_RUN;
			kind_q      <= OP_CLEAR;
			step_q      <= '0;
			last_q      <= ADDR_W'(STORE_DEPTH - 1);
			ok_q        <= 1'b1;
			report_q    <= 1'b0;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.publish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q   <= op;
						ok_q     <= guard_ok;
						step_q   <= '0;
						last_q   <= last_c;
						report_q <= 1'b1;
						state_q  <= guard_ok ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= report_q ? ST_DONE : ST_IDLE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						accepted_q  <= ok_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;

endmodule

`default_nettype wire

// ----- rtl/glyph_frame_buffer_renderer.sv -----
// Top level of the page-organized monochrome frame buffer and glyph renderer.
`default_nettype none
`include "assert_macros.svh"

// The block keeps a monochrome frame buffer of COLUMNS bytes per 8-row page
// (1024 bytes at 128 x 64) in a single RAM with one write and one registered
// read port, and serves one request transaction at a time: clear, a 5x7 text
// digit with a spacing column, a 16x16 large glyph over two pages, a digit
// scaled two times, or a read of one byte. Every request returns exactly one
// result transaction carrying read_data (zero unless it is an accepted read)
// and accepted (low when the range guard rejected the request, which then
// leaves the buffer untouched). The cost of a request is set by the RAM,
// which moves one byte per cycle: an accepted request steps through 6 bytes
// for a text character, 32 for a large glyph, 20 for a scaled digit (each of
// its bytes is read, merged and written back in a two-stage pipeline), 1 for a
// read and 1024 for a clear, and then offers its result. A rejected request
// offers its result without stepping through the buffer. After reset the block
// sweeps zeros through the whole buffer and holds in_stall high until the sweep
// has drained, before it takes its first request. A finished result sits in an
// output register, so the next request is taken while the previous result still
// waits for the downstream side.
module glyph_frame_buffer_renderer import gfbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] op,
	input  logic [6:0] column,
	input  logic [2:0] page,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       accepted
);

	// Command bundle from the sequencer to the datapath.
	gfbr_cmd_t ctrl_cmd;

	// The controller decodes the request, applies the range guards and
	// steps through the buffer bytes that the request touches.
	gfbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.column   (column),
		.page     (page),
		.symbol   (symbol),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted (accepted),
		.cmd      (ctrl_cmd)
	);

	// The datapath latches the request fields, turns each step into an
	// address, a font byte and a bit mask, and owns the frame store.
	gfbr_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctrl_cmd),
		.column   (column),
		.page     (page),
		.symbol   (symbol),
		.read_data(read_data)
	);

	// Only one request is in flight: after an input transaction the block
	// stalls its input until that request has finished.
	`ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "request taken while busy")

	// A request is never latched while buffer accesses are still issued.
	`ASSERT_IMPLY(a_load_not_running, ctrl_cmd.load, !ctrl_cmd.run, "request loaded mid-sequence")

	// A new result is published only when the output register is free.
	`ASSERT_IMPLY(a_publish_free, ctrl_cmd.publish, !out_valid || !out_stall, "result overwritten")

	// A rejected request always reports zero read data.
	`ASSERT_IMPLY(a_reject_zero, out_valid && !accepted, read_data == 8'h00, "reject with data")

endmodule

`default_nettype wire

// ----- verif/gfbr_scoreboard.sv -----
// Checker for the glyph frame buffer renderer: models the buffer and compares every result.
`timescale 1ns / 1ps

module gfbr_scoreboard import gfbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [2:0] op,
	input  logic [6:0] column,
	input  logic [2:0] page,
	input  logic [7:0] symbol,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] read_data,
	input  logic       accepted,
	output int         fail_count,
	output int         awaiting
);

	// The 5x7 font is seven pixel rows high.
	localparam int GLYPH_ROWS = 7;

	typedef struct packed {
		logic [7:0] data;
		logic       ok;
	} reply_t;

	logic [7:0] frame [STORE_DEPTH];
	reply_t     replies_due [$];
	int         mismatches = 0;

	assign fail_count = mismatches;

	function automatic void put_pixel(input int x, input int y, input logic on);
		if (x < COLUMNS && y < ROWS) begin
			frame[(y / 8) * COLUMNS + x][y % 8] = on;
		end
	endfunction

	// Applies one request to the buffer copy and returns the result it must produce.
	function automatic reply_t apply_request(input logic [2:0] kind, input logic [6:0] col,
			input logic [2:0] pg, input logic [7:0] sym);
		reply_t r;
		int     base;
		int     glyph;
		logic [7:0] bits;
		r = '0;
		base = int'(pg) * COLUMNS;
		case (kind)
			OP_CLEAR: begin
				foreach (frame[k]) frame[k] = '0;
				r.ok = 1'b1;
			end
			OP_TEXT: begin
				if (int'(pg) < PAGES && int'(col) < COLUMNS - SMALL_W) begin
					glyph = (sym >= CHAR_ZERO && sym <= CHAR_NINE) ?
						int'(sym - CHAR_ZERO) : BLANK_GLYPH;
					for (int i = 0; i < SMALL_W; i++) begin
						frame[base + int'(col) + i] = SMALL_FONT[glyph][i];
					end
					frame[base + int'(col) + SMALL_W] = '0;
					r.ok = 1'b1;
				end
			end
			OP_BIG: begin
				if (int'(sym) < BIG_COUNT && int'(pg) + 2 <= PAGES &&
						int'(col) <= COLUMNS - BIG_W) begin
					for (int i = 0; i < BIG_W; i++) begin
						frame[base + int'(col) + i] = BIG_FONT[sym][i];
						frame[base + COLUMNS + int'(col) + i] = BIG_FONT[sym][BIG_W + i];
					end
					r.ok = 1'b1;
				end
			end
			OP_DOUBLE: begin
				if (int'(sym) <= DIGIT_MAX && int'(pg) < PAGES &&
						int'(col) <= COLUMNS - DBL_W) begin
					for (int i = 0; i < SMALL_W; i++) begin
						bits = SMALL_FONT[sym][i];
						for (int row = 0; row < GLYPH_ROWS; row++) begin
							for (int dx = 0; dx < 2; dx++) begin
								for (int dy = 0; dy < 2; dy++) begin
									put_pixel(int'(col) + 2 * i + dx,
										int'(pg) * 8 + 2 * row + dy, bits[row]);
								end
							end
						end
					end
					r.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (int'(pg) < PAGES && int'(col) < COLUMNS) begin
					r.data = frame[base + int'(col)];
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t due;
		if (!arst_n) begin
			foreach (frame[k]) frame[k] = '0;
			replies_due.delete();
			awaiting <= 0;
		end else begin
			// A result never leaves in the cycle that takes its request, so compare first.
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected: read_data %02h accepted %0b",
						$time, read_data, accepted);
				end else begin
					due = replies_due.pop_front();
					if (read_data !== due.data) begin
						mismatches++;
						$display("%0t: read_data expected %02h actual %02h",
							$time, due.data, read_data);
					end
					if (accepted !== due.ok) begin
						mismatches++;
						$display("%0t: accepted expected %0b actual %0b",
							$time, due.ok, accepted);
					end
				end
			end
			if (in_valid && !in_stall) begin
				replies_due.push_back(apply_request(op, column, page, symbol));
			end
			awaiting <= replies_due.size();
		end
	end

endmodule

// ----- verif/tb_glyph_frame_buffer_renderer.sv -----
// Testbench top for the glyph frame buffer renderer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_glyph_frame_buffer_renderer import gfbr_pkg::*;;

	// Opcodes the block does not define; they must be answered as rejected.
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	// The longest quiet stretch of a correct run is the reset sweep or a clear
	// followed by a long run of receiver stalls, so this leaves a wide margin.
	localparam int QUIET_LIMIT = 10000;

	// Cycles allowed after the last result for anything stray to show up.
	localparam int SETTLE_CYCLES = 64;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] op = OP_READ;
	logic [6:0] column = '0;
	logic [2:0] page = '0;
	logic [7:0] symbol = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_data;
	logic       accepted;

	int fail_count;
	int awaiting;

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int idle_pct = 0;
	int stall_pct = 0;

	// Place of the most recent drawing, so that reads mostly land on fresh pixels.
	logic [6:0] last_col = '0;
	logic [2:0] last_pg = '0;

	always #6 clk = ~clk;

	glyph_frame_buffer_renderer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.column    (column),
		.page      (page),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_data (read_data),
		.accepted  (accepted)
	);

	gfbr_scoreboard u_scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.column      (column),
		.page        (page),
		.symbol      (symbol),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.accepted    (accepted),
		.fail_count  (fail_count),
		.awaiting    (awaiting)
	);

	// The receiver decides afresh at every edge whether to stall the next cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Presents one request transaction and returns at the edge that accepts it.
	// Idle cycles come before the request; once valid is high it stays high and
	// the payload stays put until the block takes it.
	task automatic issue(input logic [2:0] kind, input logic [6:0] col,
			input logic [2:0] pg, input logic [7:0] sym);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		column <= col;
		page <= pg;
		symbol <= sym;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
	endtask

	// Holds the sender back until every result owed by the block has arrived.
	// The first edge lets the checker count the request accepted last.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	// One random request. Most are well formed so that the drawings really land
	// in the buffer; a share of each drawing kind strays out of range to hit the
	// guards. Reads are the only way to see the buffer, so they make up about
	// half the traffic and mostly look at the area drawn last.
	task automatic random_request();
		int         pick;
		logic [2:0] kind;
		logic [6:0] col;
		logic [2:0] pg;
		logic [7:0] sym;
		pick = int'($urandom_range(99));
		col = 7'($urandom_range(COLUMNS - 1));
		pg = 3'($urandom_range(PAGES - 1));
		sym = 8'($urandom_range(255));
		if (pick < 2) begin
			kind = OP_CLEAR;
		end else if (pick < 17) begin
			kind = OP_TEXT;
			if ($urandom_range(99) < 85) col = 7'($urandom_range(COLUMNS - SMALL_W - 1));
			if ($urandom_range(99) < 75) sym = 8'(CHAR_ZERO + $urandom_range(DIGIT_MAX));
		end else if (pick < 29) begin
			kind = OP_BIG;
			if ($urandom_range(99) < 85) col = 7'($urandom_range(COLUMNS - BIG_W));
			if ($urandom_range(99) < 85) pg = 3'($urandom_range(PAGES - 2));
			if ($urandom_range(99) < 85) sym = 8'($urandom_range(BIG_COUNT - 1));
		end else if (pick < 44) begin
			kind = OP_DOUBLE;
			if ($urandom_range(99) < 85) col = 7'($urandom_range(COLUMNS - DBL_W));
			if ($urandom_range(99) < 85) sym = 8'($urandom_range(DIGIT_MAX));
		end else if (pick < 97) begin
			kind = OP_READ;
			if ($urandom_range(99) < 75) begin
				// The column wraps within its seven bits, the page within three.
				col = last_col + 7'($urandom_range(BIG_W - 1));
				pg = last_pg + 3'($urandom_range(1));
			end
		end else begin
			kind = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
		end
		if (kind == OP_TEXT || kind == OP_BIG || kind == OP_DOUBLE) begin
			last_col = col;
			last_pg = pg;
		end
		issue(kind, col, pg, sym);
	endtask

	task automatic random_phase(input int count, input int sender_pct, input int receiver_pct);
		idle_pct = sender_pct;
		stall_pct = receiver_pct;
		for (int n = 0; n < count; n++) begin
			random_request();
			// Now and then the sender waits for the block to run dry.
			if ($urandom_range(99) == 0) drain();
		end
		drain();
	endtask

	// Watchdog: a run in which no transaction moves on either channel for too
	// long has hung.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		// Reset once; the block then sweeps its buffer and holds in_stall high,
		// which the first request simply waits out.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: the buffer corners after reset, the field limits of
		// every operation on both sides of each range guard, blank text glyphs,
		// the scaled digit clipped at the bottom of the screen, and the opcodes
		// that do nothing.
		issue(OP_READ, 7'd0, 3'd0, 8'h00);
		issue(OP_READ, 7'(COLUMNS - 1), 3'(PAGES - 1), 8'hFF);
		issue(OP_TEXT, 7'd0, 3'd0, CHAR_ZERO);
		issue(OP_TEXT, 7'(COLUMNS - SMALL_W - 1), 3'(PAGES - 1), CHAR_NINE);
		issue(OP_TEXT, 7'(COLUMNS - SMALL_W), 3'd2, CHAR_ZERO);
		issue(OP_TEXT, 7'd8, 3'd1, 8'hFF);
		issue(OP_TEXT, 7'd20, 3'd1, CHAR_ZERO - 8'd1);
		issue(OP_BIG, 7'd0, 3'd0, 8'd0);
		issue(OP_BIG, 7'(COLUMNS - BIG_W), 3'(PAGES - 2), 8'(BIG_COUNT - 1));
		issue(OP_BIG, 7'd40, 3'd2, 8'(BIG_COUNT));
		issue(OP_BIG, 7'd40, 3'(PAGES - 1), 8'd2);
		issue(OP_BIG, 7'(COLUMNS - BIG_W + 1), 3'd3, 8'd3);
		issue(OP_DOUBLE, 7'd30, 3'd0, 8'd0);
		issue(OP_DOUBLE, 7'(COLUMNS - DBL_W), 3'(PAGES - 1), 8'(DIGIT_MAX));
		issue(OP_DOUBLE, 7'd50, 3'd4, 8'(DIGIT_MAX + 1));
		issue(OP_DOUBLE, 7'(COLUMNS - DBL_W + 1), 3'd4, 8'd1);
		issue(OP_UNUSED_FIRST, 7'd1, 3'd1, 8'd1);
		issue(OP_UNUSED_FIRST + 3'd1, 7'd2, 3'd2, 8'd2);
		issue(OP_UNUSED_LAST, 7'(COLUMNS - 1), 3'(PAGES - 1), 8'hFF);
		issue(OP_READ, 7'(COLUMNS - DBL_W), 3'(PAGES - 1), 8'h00);
		issue(OP_READ, 7'(COLUMNS - 1), 3'(PAGES - 1), 8'h00);
		issue(OP_READ, 7'd2, 3'd1, 8'h00);
		issue(OP_READ, 7'd31, 3'd1, 8'h00);
		issue(OP_CLEAR, 7'd0, 3'd0, 8'h00);
		issue(OP_READ, 7'd2, 3'd0, 8'h00);
		drain();

		// Random traffic in stretches of different flow control: free running,
		// a mostly idle sender, a mostly stalling receiver, both, and free again.
		random_phase(400, 0, 0);
		random_phase(300, 83, 0);
		random_phase(300, 0, 83);
		random_phase(450, 21, 21);
		random_phase(400, 0, 0);

		stall_pct = 0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && awaiting == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
